// ===== hw/rtl/iol_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iol_pkg: shared types and constants for the indexed ordered list
// Request/response payloads, request kinds, status codes, cell commands
// and the controller state encoding.
// ----------------------------------------------------------------------------
package iol_pkg;

	localparam int CAPACITY = 64;
	localparam int IX_W     = $clog2(CAPACITY);      // cell address width
	localparam int CNT_W    = $clog2(CAPACITY + 1);  // fill count width
	localparam int IDX_W    = 7;                     // index field width
	localparam int VAL_W    = 8;

	// request kinds
	localparam logic [2:0] KIND_INS_AT   = 3'd0;
	localparam logic [2:0] KIND_INS_ORD  = 3'd1;
	localparam logic [2:0] KIND_REMOVE   = 3'd2;
	localparam logic [2:0] KIND_REPLACE  = 3'd3;
	localparam logic [2:0] KIND_READ     = 3'd4;
	localparam logic [2:0] KIND_CLEAR    = 3'd5;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]              kind;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
	} iol_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [1:0]              status;
		logic [IDX_W-1:0]        position;
		logic [IDX_W-1:0]        count;
	} iol_rsp_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_REMOVE,
		ACT_WRITE
	} act_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		act_t                    act;
		logic [IDX_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] cmp_value;
		logic                    capture;
		logic [CNT_W-1:0]        len;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_APPLY
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/iol_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iol_cell: one list slot
// Holds one entry, shifts from its left or right neighbor on insert/remove,
// and registers its "greater than new value" flag on capture.
// ----------------------------------------------------------------------------
module iol_cell (
	input  wire logic                             clk,
	input  wire logic [iol_pkg::IX_W-1:0]         cell_idx,
	input  wire iol_pkg::cell_cmd_t               cmd,
	input  wire logic signed [iol_pkg::VAL_W-1:0] left_entry,
	input  wire logic signed [iol_pkg::VAL_W-1:0] right_entry,
	output logic signed [iol_pkg::VAL_W-1:0]      entry,
	output logic                                  flag
);
	import iol_pkg::*;

	logic signed [VAL_W-1:0] entry_q;
	logic                    flag_q;
	logic [IDX_W-1:0]        my_pos;
	logic                    is_pos;
	logic                    above_pos;
	logic                    gt_now;

	assign my_pos    = IDX_W'(cell_idx);
	assign is_pos    = (my_pos == cmd.pos);
	assign above_pos = (my_pos > cmd.pos);
	// live entry strictly greater than the incoming value
	assign gt_now    = (CNT_W'(cell_idx) < cmd.len) && (cmd.cmp_value < entry_q);

	always_ff @(posedge clk) begin
		unique case (cmd.act)
			ACT_INSERT: begin
				if (is_pos)
					entry_q <= cmd.value;
				else if (above_pos)
					entry_q <= left_entry;
			end
			ACT_REMOVE: begin
				if (is_pos || above_pos)
					entry_q <= right_entry;
			end
			ACT_WRITE: begin
				if (is_pos)
					entry_q <= cmd.value;
			end
			default: begin
			end
		endcase
		if (cmd.capture)
			flag_q <= gt_now;
	end

	assign entry = entry_q;
	assign flag  = flag_q;

endmodule
`default_nettype wire

// ===== hw/rtl/iol_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iol_chain: row of list cells
// Wires neighbors together, finds the first flagged cell and selects the
// entry addressed by a read.
// ----------------------------------------------------------------------------
module iol_chain (
	input  wire logic                             clk,
	input  wire iol_pkg::cell_cmd_t               cmd,
	input  wire logic [iol_pkg::IDX_W-1:0]        read_idx,
	output logic                                  found,
	output logic [iol_pkg::IDX_W-1:0]             first_pos,
	output logic signed [iol_pkg::VAL_W-1:0]      read_data
);
	import iol_pkg::*;

	logic signed [VAL_W-1:0] ent [CAPACITY];
	logic [CAPACITY-1:0]     flags;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VAL_W-1:0] left_e;
		logic signed [VAL_W-1:0] right_e;

		if (g == 0) begin : g_first
			assign left_e = '0;
		end else begin : g_mid_l
			assign left_e = ent[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid_r
			assign right_e = ent[g+1];
		end

		iol_cell u_cell (
			.clk         (clk),
			.cell_idx    (IX_W'(g)),
			.cmd         (cmd),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (ent[g]),
			.flag        (flags[g])
		);
	end

	// lowest flagged cell wins
	always_comb begin
		first_pos = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (flags[i])
				first_pos = IDX_W'(i);
		end
	end
	assign found = |flags;

	always_comb begin
		read_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (read_idx == IDX_W'(i))
				read_data = read_data | ent[i];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_ordered_list_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_ordered_list_top: bounded list of signed characters
// Insert at index, insert in order, remove, replace, read and clear on a
// row of shifting cells.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The accepting
// edge captures every cell's compare flag, the FIND state registers the
// insert position from the first flagged cell, and the APPLY state shifts or
// writes all cells at once and registers the response. done is high for
// exactly one cycle with rsp valid, in the first cycle busy is low again, so
// the next transaction can be started as soon as done is high. The receiver
// cannot stall; rsp must be taken while done is high. Entries are not cleared
// at reset; the fill count, the state and done are.
// ----------------------------------------------------------------------------
module indexed_ordered_list_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire iol_pkg::iol_req_t req,
	output logic                   done,
	output iol_pkg::iol_rsp_t      rsp
);
	import iol_pkg::*;

	state_t                  state_q, state_nx;
	logic [2:0]              kind_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] value_q;
	logic [IDX_W-1:0]        pos_q;
	logic [CNT_W-1:0]        len_q;
	logic                    done_q;
	iol_rsp_t                rsp_q;

	logic                    accept;
	logic                    found;
	logic [IDX_W-1:0]        first_pos;
	logic signed [VAL_W-1:0] read_data;
	cell_cmd_t               cmd;

	logic [IDX_W-1:0]        pos_eff;
	logic [1:0]              status;
	logic [CNT_W-1:0]        len_nx;
	logic signed [VAL_W-1:0] rd;
	act_t                    act;
	logic                    full;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign full   = (len_q >= CNT_W'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == ST_APPLY);
			if (state_q == ST_APPLY)
				len_q <= len_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.kind;
			idx_q   <= req.index;
			value_q <= req.value;
		end
		if (state_q == ST_FIND)
			pos_q <= found ? first_pos : IDX_W'(len_q);
		if (state_q == ST_APPLY) begin
			rsp_q.read_value <= rd;
			rsp_q.status     <= status;
			rsp_q.position   <= pos_eff;
			rsp_q.count      <= IDX_W'(len_nx);
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_nx = ST_FIND;
			ST_FIND:  state_nx = ST_APPLY;
			ST_APPLY: state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// request decode, used in the apply cycle
	always_comb begin
		pos_eff = (kind_q == KIND_INS_ORD) ? pos_q : idx_q;
		status  = STAT_OK;
		len_nx  = len_q;
		rd      = '0;
		act     = ACT_NONE;
		unique case (kind_q)
			KIND_INS_AT, KIND_INS_ORD: begin
				if (pos_eff > IDX_W'(len_q))
					status = STAT_RANGE;
				else if (full)
					status = STAT_FULL;
				else begin
					act    = ACT_INSERT;
					len_nx = len_q + CNT_W'(1);
				end
			end
			KIND_REMOVE: begin
				if (idx_q >= IDX_W'(len_q))
					status = STAT_RANGE;
				else begin
					act    = ACT_REMOVE;
					len_nx = len_q - CNT_W'(1);
				end
			end
			KIND_REPLACE: begin
				if (idx_q >= IDX_W'(len_q))
					status = STAT_RANGE;
				else
					act = ACT_WRITE;
			end
			KIND_READ: begin
				if (idx_q >= IDX_W'(len_q))
					status = STAT_RANGE;
				else
					rd = read_data;
			end
			KIND_CLEAR: len_nx = '0;
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd.act       = (state_q == ST_APPLY) ? act : ACT_NONE;
		cmd.pos       = pos_eff;
		cmd.value     = value_q;
		cmd.cmp_value = req.value;
		cmd.capture   = accept;
		cmd.len       = len_q;
	end

	iol_chain u_chain (
		.clk       (clk),
		.cmd       (cmd),
		.read_idx  (idx_q),
		.found     (found),
		.first_pos (first_pos),
		.read_data (read_data)
	);

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

// ===== verif/indexed_ordered_list_top_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_ordered_list_top_tb: self-checking bench for the indexed ordered list
// Sends insert, ordered insert, remove, replace, read, clear and unused-kind
// transactions. A local model of the list predicts each response, and a
// monitor compares every done strobe, field by field, against the oldest
// pending prediction. The sender idles at several rates.
// ----------------------------------------------------------------------------
module indexed_ordered_list_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iol_pkg::*;

	localparam logic [2:0] KIND_UNUSED_A = 3'd6;
	localparam logic [2:0] KIND_UNUSED_B = 3'd7;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	logic     done;
	iol_req_t req_bus = '0;
	iol_rsp_t rsp_bus;

	// list model state
	logic signed [VAL_W-1:0] list_mem [CAPACITY];
	int                      list_len = 0;

	iol_rsp_t pending_rsp [$];
	int       fail_count = 0;
	int       idle_pct = 0;
	bit       growing = 1'b1;

	indexed_ordered_list_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req_bus),
		.done   (done),
		.rsp    (rsp_bus)
	);

	always #10 clk = ~clk;

	// apply one request to the model list and return the response it produces
	function automatic iol_rsp_t apply_request(iol_req_t r);
		iol_rsp_t o;
		int       slot;
		int       k;
		o = '0;
		o.position = r.index;
		slot = int'(r.index);
		if (r.kind == KIND_INS_ORD) begin
			// lands after any equal entries
			slot = list_len;
			for (k = 0; k < list_len; k++) begin
				if ($signed(r.value) < $signed(list_mem[k])) begin
					slot = k;
					break;
				end
			end
			o.position = slot[IDX_W-1:0];
		end
		case (r.kind)
			KIND_INS_AT, KIND_INS_ORD: begin
				if (slot > list_len) begin
					o.status = STAT_RANGE;
				end else if (list_len >= CAPACITY) begin
					o.status = STAT_FULL;
				end else begin
					for (k = list_len; k > slot; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[slot] = r.value;
					list_len++;
				end
			end
			KIND_REMOVE: begin
				if (slot >= list_len) begin
					o.status = STAT_RANGE;
				end else begin
					for (k = slot; k + 1 < list_len; k++)
						list_mem[k] = list_mem[k+1];
					list_len--;
				end
			end
			KIND_REPLACE: begin
				if (slot >= list_len)
					o.status = STAT_RANGE;
				else
					list_mem[slot] = r.value;
			end
			KIND_READ: begin
				if (slot >= list_len)
					o.status = STAT_RANGE;
				else
					o.read_value = list_mem[slot];
			end
			KIND_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		o.count = list_len[IDX_W-1:0];
		return o;
	endfunction

	// entered just after a rising edge; returns at the edge that took the transaction
	task automatic send_req(input logic [2:0] kind, input logic [IDX_W-1:0] index,
				input logic [VAL_W-1:0] value);
		iol_req_t r;
		r.kind = kind;
		r.index = index;
		r.value = value;
		@(negedge clk);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req_bus <= r;
		// busy only moves on rising edges, so its value here holds at the next one
		while (busy)
			@(negedge clk);
		@(posedge clk);
		pending_rsp.push_back(apply_request(r));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// response monitor
	always @(posedge clk) begin
		iol_rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response %p", $time, rsp_bus);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_bus.read_value !== want.read_value) begin
					$display("%0t: read_value expected %0d got %0d", $time,
						 want.read_value, rsp_bus.read_value);
					fail_count++;
				end
				if (rsp_bus.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						 want.status, rsp_bus.status);
					fail_count++;
				end
				if (rsp_bus.position !== want.position) begin
					$display("%0t: position expected %0d got %0d", $time,
						 want.position, rsp_bus.position);
					fail_count++;
				end
				if (rsp_bus.count !== want.count) begin
					$display("%0t: count expected %0d got %0d", $time,
						 want.count, rsp_bus.count);
					fail_count++;
				end
			end
		end
	end

	task automatic test_empty_list();
		send_req(KIND_READ, 7'd0, 8'h00);
		send_req(KIND_REMOVE, 7'd0, 8'h00);
		send_req(KIND_REPLACE, 7'd0, 8'h55);
		send_req(KIND_INS_AT, 7'd1, 8'h11);     // past the end
		send_req(KIND_READ, 7'd127, 8'hff);
		send_req(KIND_UNUSED_A, 7'd42, 8'h80);
		send_req(KIND_UNUSED_B, 7'd127, 8'h7f);
	endtask

	task automatic test_basic_ops();
		send_req(KIND_INS_AT, 7'd0, 8'h80);
		send_req(KIND_INS_ORD, 7'd0, 8'h7f);
		send_req(KIND_INS_ORD, 7'd99, 8'h00);
		send_req(KIND_INS_ORD, 7'd0, 8'h00);    // equal value goes after
		send_req(KIND_INS_ORD, 7'd0, 8'h80);
		send_req(KIND_INS_AT, 7'd5, 8'h55);     // back push
		send_req(KIND_READ, 7'd0, 8'h00);
		send_req(KIND_READ, 7'd5, 8'h00);
		send_req(KIND_REPLACE, 7'd2, 8'hff);
		send_req(KIND_READ, 7'd2, 8'h00);
		send_req(KIND_REMOVE, 7'd0, 8'h00);     // front pop
		send_req(KIND_REMOVE, 7'd4, 8'h00);     // back pop
		send_req(KIND_REMOVE, 7'd1, 8'h00);
		send_req(KIND_READ, 7'd3, 8'h00);       // index equals count
		send_req(KIND_CLEAR, 7'd64, 8'haa);
		send_req(KIND_READ, 7'd0, 8'h00);
	endtask

	task automatic test_full_list();
		logic [VAL_W-1:0] v;
		while (list_len < CAPACITY) begin
			v = 8'($urandom());
			if ($urandom_range(1, 0) == 1)
				send_req(KIND_INS_ORD, 7'($urandom()), v);
			else
				send_req(KIND_INS_AT, 7'($urandom_range(list_len, 0)), v);
		end
		send_req(KIND_INS_AT, 7'd64, 8'h01);
		send_req(KIND_INS_AT, 7'd0, 8'hfe);
		send_req(KIND_INS_ORD, 7'd0, 8'($urandom()));
		send_req(KIND_INS_AT, 7'd65, 8'h02);    // range check wins over full
		send_req(KIND_INS_AT, 7'd127, 8'h03);
		send_req(KIND_READ, 7'd63, 8'h00);
		send_req(KIND_READ, 7'd64, 8'h00);
		send_req(KIND_REPLACE, 7'd63, 8'h7f);
		send_req(KIND_REMOVE, 7'd63, 8'h00);
		send_req(KIND_INS_ORD, 7'd0, 8'h7f);
		send_req(KIND_INS_ORD, 7'd0, 8'h00);    // full again
		send_req(KIND_CLEAR, 7'd0, 8'h00);
	endtask

	task automatic test_random(input int n_items, input int pct);
		int              roll;
		logic [2:0]      kind;
		logic [IDX_W-1:0] index;
		idle_pct = pct;
		repeat (n_items) begin
			if (list_len >= CAPACITY)
				growing = 1'b0;
			else if (list_len == 0)
				growing = 1'b1;
			roll = $urandom_range(99, 0);
			if (growing) begin
				if (roll < 35)      kind = KIND_INS_AT;
				else if (roll < 70) kind = KIND_INS_ORD;
				else if (roll < 78) kind = KIND_REMOVE;
				else if (roll < 86) kind = KIND_REPLACE;
				else if (roll < 97) kind = KIND_READ;
				else if (roll < 98) kind = KIND_CLEAR;
				else                kind = ($urandom_range(1, 0) == 1) ? KIND_UNUSED_A
										   : KIND_UNUSED_B;
			end else begin
				if (roll < 10)      kind = KIND_INS_AT;
				else if (roll < 20) kind = KIND_INS_ORD;
				else if (roll < 60) kind = KIND_REMOVE;
				else if (roll < 72) kind = KIND_REPLACE;
				else if (roll < 95) kind = KIND_READ;
				else if (roll < 97) kind = KIND_CLEAR;
				else                kind = ($urandom_range(1, 0) == 1) ? KIND_UNUSED_A
										   : KIND_UNUSED_B;
			end
			// mostly in-range indexes, some anywhere in the field
			if ($urandom_range(9, 0) == 0 || (kind != KIND_INS_AT && list_len == 0))
				index = 7'($urandom());
			else if (kind == KIND_INS_AT)
				index = 7'($urandom_range(list_len, 0));
			else
				index = 7'($urandom_range(list_len - 1, 0));
			send_req(kind, index, 8'($urandom()));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		test_empty_list();
		test_basic_ops();
		idle_pct = 73;
		test_full_list();
		test_random(125, 0);
		test_random(125, 73);
		test_random(125, 9);
		stop_sending();

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("indexed_ordered_list_top_tb OK");
		end else begin
			$display("indexed_ordered_list_top_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("%0t: timeout", $time);
		$display("indexed_ordered_list_top_tb NOT OK");
		$finish;
	end

endmodule
